@@ rtl/segment_grid_crossings_defines.svh @@
// Assertion macros for the segment grid crossings block.
// Included by the RTL files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef SEGMENT_GRID_CROSSINGS_DEFINES_SVH
`define SEGMENT_GRID_CROSSINGS_DEFINES_SVH
`ifndef SYNTHESIS
`define SGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SGC_ASSERT(lbl, prop, msg)
`define SGC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/sgc_pkg.sv @@
// Package for the segment grid crossings block: widths, limits and the
// request/response types of the shared multiply/divide unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sgc_pkg;
  localparam int INT_BITS  = 10;
  localparam int FRAC_BITS = 14;
  localparam int MAX_SPAN  = 32;
  localparam int CW        = INT_BITS + FRAC_BITS;
  localparam int PW        = 2 * CW;
  localparam int LW        = INT_BITS + 1;
  localparam int KW        = $clog2(MAX_SPAN + 1);
  localparam int SW        = $clog2(CW);

  typedef struct packed {
    logic          start;
    logic          div;
    logic [CW-1:0] a;
    logic [CW-1:0] b;
    logic [CW-1:0] den;
  } unit_req_t;

  typedef struct packed {
    logic          done;
    logic [PW-1:0] prod;
    logic [CW-1:0] quo;
    logic          rem_nz;
  } unit_rsp_t;
endpackage
`default_nettype wire

@@ rtl/sgc_unit.sv @@
// Shared arithmetic unit: one 24x24 multiply, optionally followed by a
// restoring divide of the product, one quotient bit per cycle. Uses sgc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sgc_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sgc_pkg::unit_req_t req_i,
  output sgc_pkg::unit_rsp_t rsp_o
);
  import sgc_pkg::*;

  typedef enum logic [2:0] {
    U_IDLE = 3'b001,
    U_MUL  = 3'b010,
    U_DIV  = 3'b100
  } ustate_e;

  ustate_e       state_q;
  logic          div_q, done_q;
  logic [CW-1:0] a_q, b_q, den_q, rem_q, low_q;
  logic [SW-1:0] cnt_q;
  logic [PW-1:0] prod;
  logic [CW:0]   trial;
  logic          ge;

  assign prod  = a_q * b_q;
  assign trial = {rem_q, low_q[CW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= (state_q == U_MUL && !div_q) ||
                (state_q == U_DIV && cnt_q == SW'(CW - 1));
      unique case (state_q)
        U_IDLE: begin
          if (req_i.start) begin
            a_q     <= req_i.a;
            b_q     <= req_i.b;
            den_q   <= req_i.den;
            div_q   <= req_i.div;
            state_q <= U_MUL;
          end
        end
        U_MUL: begin
          rem_q <= prod[PW-1:CW];
          low_q <= prod[CW-1:0];
          cnt_q <= '0;
          if (div_q) begin
            state_q <= U_DIV;
          end else begin
            state_q <= U_IDLE;
          end
        end
        U_DIV: begin
          // remainder stays below den, so the high half fits CW bits
          rem_q <= ge ? CW'(trial - {1'b0, den_q}) : trial[CW-1:0];
          low_q <= {low_q[CW-2:0], ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == SW'(CW - 1)) begin
            state_q <= U_IDLE;
          end
        end
        default: state_q <= U_IDLE;
      endcase
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.prod   = {rem_q, low_q};
  assign rsp_o.quo    = low_q;
  assign rsp_o.rem_nz = |rem_q;
endmodule
`default_nettype wire

@@ rtl/segment_grid_crossings.sv @@
// Segment grid crossings: top level, sequencer and result buffer.
// Depends on sgc_pkg, sgc_unit and segment_grid_crossings_defines.svh.
//
// Usage: drive ax_i, ay_i, bx_i, by_i (unsigned Q10.14) with start_i; the
// segment is taken at a clock edge where start_i is high and busy_o is low.
// busy_o stays high until the last result of that segment has been issued.
// Results come out one per strobe on res_valid_o, each for one cycle, in order
// of travel from a to b; last_o marks the final one. A segment with no
// crossing gives one result with valid_res_o low; one spanning too many grid
// lines gives one result with too_long_o high.
// Flow: each crossing runs through the shared multiply/divide unit as a
// multiply-divide of 24 restoring steps; when a vertical and a horizontal
// candidate must be ordered, two plain multiplies first form the two cross
// products. A segment has at most 32 vertical and 32 horizontal crossings.
// Reset clears the sequencer; no result is pending afterwards. The receiver
// cannot stall: each result is taken in the cycle it is shown.
`timescale 1ns / 1ps
`default_nettype none
`include "segment_grid_crossings_defines.svh"
module segment_grid_crossings (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [sgc_pkg::CW-1:0] ax_i,
  input  logic [sgc_pkg::CW-1:0] ay_i,
  input  logic [sgc_pkg::CW-1:0] bx_i,
  input  logic [sgc_pkg::CW-1:0] by_i,
  output logic                   res_valid_o,
  output logic [sgc_pkg::CW-1:0] cross_x_o,
  output logic [sgc_pkg::CW-1:0] cross_y_o,
  output logic                   on_vertical_line_o,
  output logic                   valid_res_o,
  output logic                   too_long_o,
  output logic                   last_o
);
  import sgc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PREP   = 8'b0000_0010,
    S_HSTART = 8'b0000_0100,
    S_HWAIT  = 8'b0000_1000,
    S_CHOOSE = 8'b0001_0000,
    S_CMP1   = 8'b0010_0000,
    S_CMP2   = 8'b0100_0000,
    S_VWAIT  = 8'b1000_0000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] ax_q, ay_q, bx_q, by_q;
  logic [KW-1:0] kv_q, kh_q;
  logic          hav_q;
  logic [CW-1:0] hx_q;
  logic [PW-1:0] p1_q;
  logic          pend_vld_q, pend_vert_q;
  logic [CW-1:0] pend_x_q, pend_y_q;
  logic          res_valid_q, vert_q, vres_q, tl_q, last_q;
  logic [CW-1:0] res_x_q, res_y_q;

  unit_req_t     req;
  unit_rsp_t     rsp;

  logic          xinc, yinc;
  logic [CW-1:0] dx, dy, xlo, xhi, ylo, yhi;
  logic [LW-1:0] fx, lx, fy, ly, cv, ch, vline, hline;
  logic [CW-1:0] vx_cur, hy_cur, u_cur, v_cur, x_interp, y_interp;
  logic          vav, hrem, corner;
  logic          emit_en, emit_vert, fin, tl, kv_inc, kh_inc, hav_set, hav_clr, p1_ld;
  logic [CW-1:0] emit_x, emit_y;

  sgc_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign xinc = ax_q < bx_q;
  assign yinc = ay_q < by_q;
  assign xlo  = xinc ? ax_q : bx_q;
  assign xhi  = xinc ? bx_q : ax_q;
  assign ylo  = yinc ? ay_q : by_q;
  assign yhi  = yinc ? by_q : ay_q;
  assign dx   = xhi - xlo;
  assign dy   = yhi - ylo;

  // grid lines strictly between the endpoints
  assign fx = LW'(xlo >> FRAC_BITS) + 1'b1;
  assign lx = LW'((xhi - 1'b1) >> FRAC_BITS);
  assign fy = LW'(ylo >> FRAC_BITS) + 1'b1;
  assign ly = LW'((yhi - 1'b1) >> FRAC_BITS);
  assign cv = (dx != '0 && lx >= fx) ? LW'(lx - fx + 1'b1) : '0;
  assign ch = (dy != '0 && ly >= fy) ? LW'(ly - fy + 1'b1) : '0;

  assign vline  = xinc ? LW'(fx + LW'(kv_q)) : LW'(lx - LW'(kv_q));
  assign hline  = yinc ? LW'(fy + LW'(kh_q)) : LW'(ly - LW'(kh_q));
  assign vx_cur = {vline[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
  assign hy_cur = {hline[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
  assign u_cur  = (vx_cur > ax_q) ? vx_cur - ax_q : ax_q - vx_cur;
  assign v_cur  = (hy_cur > ay_q) ? hy_cur - ay_q : ay_q - hy_cur;

  // floored interpolation from the unit's quotient and remainder
  assign x_interp = xinc ? ax_q + rsp.quo : ax_q - rsp.quo - CW'(rsp.rem_nz);
  assign y_interp = yinc ? ay_q + rsp.quo : ay_q - rsp.quo - CW'(rsp.rem_nz);

  assign vav    = LW'(kv_q) < cv;
  assign hrem   = LW'(kh_q) < ch;
  // corner: already covered by the vertical crossing
  assign corner = !rsp.rem_nz && x_interp[FRAC_BITS-1:0] == '0 && dx != '0;

  always_comb begin
    state_d   = state_q;
    req       = '0;
    emit_en   = 1'b0;
    emit_vert = 1'b0;
    emit_x    = hx_q;
    emit_y    = hy_cur;
    fin       = 1'b0;
    tl        = 1'b0;
    kv_inc    = 1'b0;
    kh_inc    = 1'b0;
    hav_set   = 1'b0;
    hav_clr   = 1'b0;
    p1_ld     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_PREP;
      end
      S_PREP: begin
        if (cv > LW'(MAX_SPAN) || ch > LW'(MAX_SPAN)) begin
          tl      = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_HSTART;
        end
      end
      S_HSTART: begin
        if (hrem) begin
          req.start = 1'b1;
          req.div   = 1'b1;
          req.a     = dx;
          req.b     = v_cur;
          req.den   = dy;
          state_d   = S_HWAIT;
        end else begin
          state_d = S_CHOOSE;
        end
      end
      S_HWAIT: begin
        if (rsp.done) begin
          if (corner) begin
            kh_inc  = 1'b1;
            state_d = S_HSTART;
          end else begin
            hav_set = 1'b1;
            state_d = S_CHOOSE;
          end
        end
      end
      S_CHOOSE: begin
        priority if (vav && hav_q) begin
          req.start = 1'b1;
          req.a     = u_cur;
          req.b     = dy;
          state_d   = S_CMP1;
        end else if (vav) begin
          req.start = 1'b1;
          req.div   = 1'b1;
          req.a     = dy;
          req.b     = u_cur;
          req.den   = dx;
          state_d   = S_VWAIT;
        end else if (hav_q) begin
          emit_en = 1'b1;
          kh_inc  = 1'b1;
          hav_clr = 1'b1;
          state_d = S_HSTART;
        end else begin
          fin     = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_CMP1: begin
        if (rsp.done) begin
          p1_ld     = 1'b1;
          req.start = 1'b1;
          req.a     = v_cur;
          req.b     = dx;
          state_d   = S_CMP2;
        end
      end
      S_CMP2: begin
        if (rsp.done) begin
          if (p1_q <= rsp.prod) begin
            req.start = 1'b1;
            req.div   = 1'b1;
            req.a     = dy;
            req.b     = u_cur;
            req.den   = dx;
            state_d   = S_VWAIT;
          end else begin
            emit_en = 1'b1;
            kh_inc  = 1'b1;
            hav_clr = 1'b1;
            state_d = S_HSTART;
          end
        end
      end
      S_VWAIT: begin
        if (rsp.done) begin
          emit_en   = 1'b1;
          emit_vert = 1'b1;
          emit_x    = vx_cur;
          emit_y    = y_interp;
          kv_inc    = 1'b1;
          state_d   = S_CHOOSE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kv_q        <= '0;
      kh_q        <= '0;
      hav_q       <= 1'b0;
      pend_vld_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= tl || fin || (emit_en && pend_vld_q);
      if (state_q == S_IDLE && start_i) begin
        ax_q       <= ax_i;
        ay_q       <= ay_i;
        bx_q       <= bx_i;
        by_q       <= by_i;
        kv_q       <= '0;
        kh_q       <= '0;
        hav_q      <= 1'b0;
        pend_vld_q <= 1'b0;
      end
      if (kv_inc) kv_q <= kv_q + 1'b1;
      if (kh_inc) kh_q <= kh_q + 1'b1;
      if (hav_set) begin
        hav_q <= 1'b1;
        hx_q  <= x_interp;
      end
      if (hav_clr) hav_q <= 1'b0;
      if (p1_ld) p1_q <= rsp.prod;
      if (tl) begin
        res_x_q     <= '0;
        res_y_q     <= '0;
        vert_q      <= 1'b0;
        vres_q      <= 1'b0;
        tl_q        <= 1'b1;
        last_q      <= 1'b1;
      end
      // hold one crossing back so the final one can carry last
      if (emit_en) begin
        if (pend_vld_q) begin
          res_x_q     <= pend_x_q;
          res_y_q     <= pend_y_q;
          vert_q      <= pend_vert_q;
          vres_q      <= 1'b1;
          tl_q        <= 1'b0;
          last_q      <= 1'b0;
        end
        pend_vld_q  <= 1'b1;
        pend_x_q    <= emit_x;
        pend_y_q    <= emit_y;
        pend_vert_q <= emit_vert;
      end
      if (fin) begin
        res_x_q     <= pend_vld_q ? pend_x_q : '0;
        res_y_q     <= pend_vld_q ? pend_y_q : '0;
        vert_q      <= pend_vld_q & pend_vert_q;
        vres_q      <= pend_vld_q;
        tl_q        <= 1'b0;
        last_q      <= 1'b1;
        pend_vld_q  <= 1'b0;
      end
    end
  end

  assign busy_o             = state_q != S_IDLE;
  assign res_valid_o        = res_valid_q;
  assign cross_x_o          = res_x_q;
  assign cross_y_o          = res_y_q;
  assign on_vertical_line_o = vert_q;
  assign valid_res_o        = vres_q;
  assign too_long_o         = tl_q;
  assign last_o             = last_q;

  `SGC_ASSERT(a_tl_excl, res_valid_o |-> !(valid_res_o && too_long_o), "too_long with valid")
  `SGC_ASSERT(a_tl_last, (res_valid_o && too_long_o) |-> last_o, "too_long result not last")
  `SGC_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o, "accepted segment not busy")
  `SGC_ASSERT(a_done_wait, rsp.done |-> |(state_q & (S_HWAIT|S_CMP1|S_CMP2|S_VWAIT)), "stray done")
  `SGC_ASSERT_NEXT(a_last_idle, res_valid_o && last_o, !res_valid_o, "result after last")
endmodule
`default_nettype wire
